[hdl/mptl_pkg.sv]
// Shared types and constants for the max-pieces three-lengths DP unit.
// No dependencies; used by every module under hdl/.
package mptl_pkg;

  localparam int LEN_W = 10;
  localparam int CNT_W = 11;
  localparam int TIME_MAX = (2 ** LEN_W) - 1;
  localparam logic [CNT_W-1:0] UNREACH = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_AB,
    ST_FILL_C,
    ST_FILL_LAST,
    ST_SEARCH,
    ST_TRACE,
    ST_DONE
  } mptl_state_t;

  typedef struct packed {
    logic             reach;
    logic [CNT_W-1:0] value;
    logic [LEN_W-1:0] len;
  } mptl_choice_t;

  typedef struct packed {
    logic             status;
    logic [LEN_W-1:0] used_time;
    logic [LEN_W-1:0] leftover_time;
    logic [LEN_W-1:0] task_count;
    logic [LEN_W-1:0] uses_a;
    logic [LEN_W-1:0] uses_b;
    logic [LEN_W-1:0] uses_c;
  } mptl_result_t;

endpackage

[hdl/mptl_tables.sv]
// Count table (two read ports) and predecessor table (one read port).
// Synchronous memories with registered read. Depends on mptl_pkg.
module mptl_tables #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       cnt_we,
  input  logic [AW-1:0]              cnt_waddr,
  input  logic [mptl_pkg::CNT_W-1:0] cnt_wdata,
  input  logic [AW-1:0]              cnt_raddr0,
  input  logic [AW-1:0]              cnt_raddr1,
  output logic [mptl_pkg::CNT_W-1:0] cnt_rdata0,
  output logic [mptl_pkg::CNT_W-1:0] cnt_rdata1,
  input  logic                       pred_we,
  input  logic [AW-1:0]              pred_waddr,
  input  logic [AW-1:0]              pred_wdata,
  input  logic [AW-1:0]              pred_raddr,
  output logic [AW-1:0]              pred_rdata
);

  logic [mptl_pkg::CNT_W-1:0] cnt_mem [DEPTH];
  logic [AW-1:0]              pred_mem [DEPTH];
  logic [mptl_pkg::CNT_W-1:0] cnt_rdata0_r;
  logic [mptl_pkg::CNT_W-1:0] cnt_rdata1_r;
  logic [AW-1:0]              pred_rdata_r;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata0_r <= cnt_mem[cnt_raddr0];
    cnt_rdata1_r <= cnt_mem[cnt_raddr1];
  end

  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[pred_waddr] <= pred_wdata;
    end
    pred_rdata_r <= pred_mem[pred_raddr];
  end

  assign cnt_rdata0 = cnt_rdata0_r;
  assign cnt_rdata1 = cnt_rdata1_r;
  assign pred_rdata = pred_rdata_r;

endmodule

[hdl/mptl_choose.sv]
// Three-way best-count selection for one table entry.
// Ties go to length a, then b. Depends on mptl_pkg.
module mptl_choose #(
  parameter int AW = 10
) (
  input  logic [AW-1:0]              t,
  input  logic [mptl_pkg::LEN_W-1:0] la,
  input  logic [mptl_pkg::LEN_W-1:0] lb,
  input  logic [mptl_pkg::LEN_W-1:0] lc,
  input  logic [mptl_pkg::CNT_W-1:0] ca_raw,
  input  logic [mptl_pkg::CNT_W-1:0] cb_raw,
  input  logic [mptl_pkg::CNT_W-1:0] cc_raw,
  output mptl_pkg::mptl_choice_t     choice
);

  logic [mptl_pkg::LEN_W-1:0] t_ext;
  logic [mptl_pkg::CNT_W-1:0] ca;
  logic [mptl_pkg::CNT_W-1:0] cb;
  logic [mptl_pkg::CNT_W-1:0] cc;
  logic [mptl_pkg::CNT_W-1:0] best;
  logic                       pick_a;
  logic                       pick_b;

  function automatic logic ge(input logic [mptl_pkg::CNT_W-1:0] x,
                              input logic [mptl_pkg::CNT_W-1:0] y);
    if (x == mptl_pkg::UNREACH) begin
      return y == mptl_pkg::UNREACH;
    end
    if (y == mptl_pkg::UNREACH) begin
      return 1'b1;
    end
    return x >= y;
  endfunction

  assign t_ext = mptl_pkg::LEN_W'(t);
  assign ca = (la == '0 || la > t_ext) ? mptl_pkg::UNREACH : ca_raw;
  assign cb = (lb == '0 || lb > t_ext) ? mptl_pkg::UNREACH : cb_raw;
  assign cc = (lc == '0 || lc > t_ext) ? mptl_pkg::UNREACH : cc_raw;

  assign pick_a = ge(ca, cb) && ge(ca, cc);
  assign pick_b = ge(cb, ca) && ge(cb, cc);

  always_comb begin
    if (pick_a) begin
      best       = ca;
      choice.len = la;
    end else if (pick_b) begin
      best       = cb;
      choice.len = lb;
    end else begin
      best       = cc;
      choice.len = lc;
    end
    choice.reach = (best != mptl_pkg::UNREACH);
    choice.value = choice.reach ? best + mptl_pkg::CNT_W'(1) : mptl_pkg::UNREACH;
  end

endmodule

[hdl/mptl_seq.sv]
// Sequencer: table fill, downward search and predecessor walk.
// Depends on mptl_pkg and mptl_choose; drives the mptl_tables ports.
module mptl_seq #(
  parameter int TOTAL_CAP = 1023,
  parameter int AW        = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [mptl_pkg::LEN_W-1:0] in_total_time,
  input  logic [mptl_pkg::LEN_W-1:0] in_length_a,
  input  logic [mptl_pkg::LEN_W-1:0] in_length_b,
  input  logic [mptl_pkg::LEN_W-1:0] in_length_c,
  output logic                       busy,
  output logic                       res_valid,
  input  logic                       res_take,
  output mptl_pkg::mptl_result_t     res,
  output logic                       cnt_we,
  output logic [AW-1:0]              cnt_waddr,
  output logic [mptl_pkg::CNT_W-1:0] cnt_wdata,
  output logic [AW-1:0]              cnt_raddr0,
  output logic [AW-1:0]              cnt_raddr1,
  input  logic [mptl_pkg::CNT_W-1:0] cnt_rdata0,
  input  logic [mptl_pkg::CNT_W-1:0] cnt_rdata1,
  output logic                       pred_we,
  output logic [AW-1:0]              pred_waddr,
  output logic [AW-1:0]              pred_wdata,
  output logic [AW-1:0]              pred_raddr,
  input  logic [AW-1:0]              pred_rdata
);

  localparam logic [mptl_pkg::LEN_W-1:0] CAP_LEN = mptl_pkg::LEN_W'(TOTAL_CAP);

  mptl_pkg::mptl_state_t      state_r, state_nxt;
  logic [AW-1:0]              t_r, t_nxt;
  logic [AW-1:0]              total_r, total_nxt;
  logic [mptl_pkg::LEN_W-1:0] la_r, la_nxt;
  logic [mptl_pkg::LEN_W-1:0] lb_r, lb_nxt;
  logic [mptl_pkg::LEN_W-1:0] lc_r, lc_nxt;
  logic                       pend_r, pend_nxt;
  logic                       fwd_a_r, fwd_a_nxt;
  logic                       fwd_b_r, fwd_b_nxt;
  logic [mptl_pkg::CNT_W-1:0] fwdval_r, fwdval_nxt;
  logic [mptl_pkg::CNT_W-1:0] ca_r, ca_nxt;
  logic [mptl_pkg::CNT_W-1:0] cb_r, cb_nxt;
  logic [AW-1:0]              u_r, u_nxt;
  logic [AW-1:0]              daddr_r, daddr_nxt;
  logic                       dv_r, dv_nxt;
  logic                       status_r, status_nxt;
  logic [AW-1:0]              used_r, used_nxt;
  logic [mptl_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  logic [mptl_pkg::LEN_W-1:0] ua_r, ua_nxt;
  logic [mptl_pkg::LEN_W-1:0] ub_r, ub_nxt;
  logic [mptl_pkg::LEN_W-1:0] uc_r, uc_nxt;

  logic [AW-1:0]              wt;
  logic [AW-1:0]              addr_a;
  logic [AW-1:0]              addr_b;
  logic [AW-1:0]              addr_c;
  logic [AW-1:0]              step;
  logic [mptl_pkg::LEN_W-1:0] step_ext;
  logic [AW-1:0]              total_sat;
  logic                       do_wr;
  mptl_pkg::mptl_choice_t     choice;

  assign wt = (state_r == mptl_pkg::ST_FILL_LAST) ? t_r : t_r - AW'(1);
  assign addr_a = t_r - AW'(la_r);
  assign addr_b = t_r - AW'(lb_r);
  assign addr_c = t_r - AW'(lc_r);
  assign step = t_r - pred_rdata;
  assign step_ext = mptl_pkg::LEN_W'(step);
  assign total_sat = (in_total_time > CAP_LEN) ? AW'(TOTAL_CAP) : AW'(in_total_time);
  assign do_wr = (state_r == mptl_pkg::ST_FILL_AB && pend_r) ||
                 (state_r == mptl_pkg::ST_FILL_LAST);

  mptl_choose #(.AW(AW)) u_choose (
    .t      (wt),
    .la     (la_r),
    .lb     (lb_r),
    .lc     (lc_r),
    .ca_raw (ca_r),
    .cb_raw (cb_r),
    .cc_raw (cnt_rdata1),
    .choice (choice)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mptl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    total_r  <= total_nxt;
    la_r     <= la_nxt;
    lb_r     <= lb_nxt;
    lc_r     <= lc_nxt;
    pend_r   <= pend_nxt;
    fwd_a_r  <= fwd_a_nxt;
    fwd_b_r  <= fwd_b_nxt;
    fwdval_r <= fwdval_nxt;
    ca_r     <= ca_nxt;
    cb_r     <= cb_nxt;
    u_r      <= u_nxt;
    daddr_r  <= daddr_nxt;
    dv_r     <= dv_nxt;
    status_r <= status_nxt;
    used_r   <= used_nxt;
    cnt_r    <= cnt_nxt;
    ua_r     <= ua_nxt;
    ub_r     <= ub_nxt;
    uc_r     <= uc_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    t_nxt      = t_r;
    total_nxt  = total_r;
    la_nxt     = la_r;
    lb_nxt     = lb_r;
    lc_nxt     = lc_r;
    pend_nxt   = pend_r;
    fwd_a_nxt  = fwd_a_r;
    fwd_b_nxt  = fwd_b_r;
    fwdval_nxt = fwdval_r;
    ca_nxt     = ca_r;
    cb_nxt     = cb_r;
    u_nxt      = u_r;
    daddr_nxt  = daddr_r;
    dv_nxt     = dv_r;
    status_nxt = status_r;
    used_nxt   = used_r;
    cnt_nxt    = cnt_r;
    ua_nxt     = ua_r;
    ub_nxt     = ub_r;
    uc_nxt     = uc_r;

    cnt_we     = do_wr;
    cnt_waddr  = wt;
    cnt_wdata  = choice.value;
    cnt_raddr0 = addr_a;
    cnt_raddr1 = addr_b;
    pred_we    = do_wr && choice.reach;
    pred_waddr = wt;
    pred_wdata = wt - AW'(choice.len);
    pred_raddr = pred_rdata;
    res_valid  = 1'b0;

    unique case (state_r)
      mptl_pkg::ST_IDLE: begin
        if (in_valid) begin
          cnt_we     = 1'b1;
          cnt_waddr  = '0;
          cnt_wdata  = '0;
          pred_we    = 1'b1;
          pred_waddr = '0;
          pred_wdata = '0;
          total_nxt  = total_sat;
          la_nxt     = in_length_a;
          lb_nxt     = in_length_b;
          lc_nxt     = in_length_c;
          t_nxt      = AW'(1);
          pend_nxt   = 1'b0;
          status_nxt = 1'b0;
          used_nxt   = '0;
          cnt_nxt    = '0;
          ua_nxt     = '0;
          ub_nxt     = '0;
          uc_nxt     = '0;
          state_nxt  = (total_sat == '0) ? mptl_pkg::ST_DONE : mptl_pkg::ST_FILL_AB;
        end
      end
      mptl_pkg::ST_FILL_AB: begin
        // entry wt is written this cycle; reads of it return stale data
        fwd_a_nxt  = pend_r && (addr_a == wt);
        fwd_b_nxt  = pend_r && (addr_b == wt);
        fwdval_nxt = choice.value;
        state_nxt  = mptl_pkg::ST_FILL_C;
      end
      mptl_pkg::ST_FILL_C: begin
        cnt_raddr1 = addr_c;
        ca_nxt = fwd_a_r ? fwdval_r : cnt_rdata0;
        cb_nxt = fwd_b_r ? fwdval_r : cnt_rdata1;
        if (t_r == total_r) begin
          state_nxt = mptl_pkg::ST_FILL_LAST;
        end else begin
          t_nxt     = t_r + AW'(1);
          pend_nxt  = 1'b1;
          state_nxt = mptl_pkg::ST_FILL_AB;
        end
      end
      mptl_pkg::ST_FILL_LAST: begin
        u_nxt     = total_r;
        dv_nxt    = 1'b0;
        state_nxt = mptl_pkg::ST_SEARCH;
      end
      mptl_pkg::ST_SEARCH: begin
        cnt_raddr0 = u_r;
        daddr_nxt  = u_r;
        dv_nxt     = 1'b1;
        if (u_r != '0) begin
          u_nxt = u_r - AW'(1);
        end
        if (dv_r && cnt_rdata0 != mptl_pkg::UNREACH) begin
          used_nxt = daddr_r;
          cnt_nxt  = cnt_rdata0[mptl_pkg::LEN_W-1:0];
          if (daddr_r == '0) begin
            status_nxt = 1'b1;
            state_nxt  = mptl_pkg::ST_DONE;
          end else begin
            pred_raddr = daddr_r;
            t_nxt      = daddr_r;
            state_nxt  = mptl_pkg::ST_TRACE;
          end
        end
      end
      mptl_pkg::ST_TRACE: begin
        if (pred_rdata >= t_r) begin
          state_nxt = mptl_pkg::ST_DONE;
        end else begin
          if (step_ext == la_r) begin
            ua_nxt = ua_r + mptl_pkg::LEN_W'(1);
          end
          if (step_ext == lb_r) begin
            ub_nxt = ub_r + mptl_pkg::LEN_W'(1);
          end
          if (step_ext == lc_r) begin
            uc_nxt = uc_r + mptl_pkg::LEN_W'(1);
          end
          t_nxt = pred_rdata;
          if (pred_rdata == '0) begin
            state_nxt = mptl_pkg::ST_DONE;
          end
        end
      end
      mptl_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = mptl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mptl_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != mptl_pkg::ST_IDLE);

  assign res.status        = status_r;
  assign res.used_time     = mptl_pkg::LEN_W'(used_r);
  assign res.leftover_time = mptl_pkg::LEN_W'(total_r - used_r);
  assign res.task_count    = cnt_r;
  assign res.uses_a        = ua_r;
  assign res.uses_b        = ub_r;
  assign res.uses_c        = uc_r;

endmodule

[hdl/max_pieces_three_lengths_dp_unit.sv]
// Top level of the max-pieces three-lengths DP unit: tables, sequencer, output register.
// Depends on mptl_pkg, mptl_tables, mptl_seq (which holds mptl_choose).
//
//   channel | ports                                   | moves on
//   in      | in_valid, in_stall, in_total_time, ...  | in_valid & !in_stall
//   out     | out_valid, out_stall, out_status, ...   | out_valid & !out_stall
//
// The fill reads each entry's a and b predecessors in ST_FILL_AB and its c
// predecessor in ST_FILL_C, on the count table's two read ports; the search and
// the predecessor walk handle one entry per cycle. A zero total goes from idle
// straight to done. Reset (rst_n low, synchronous) idles the sequencer and empties
// the output register; tables need no clearing.
// in_stall is high while a request is in work; the output register lets the next
// request in while a result waits on out_stall.
module max_pieces_three_lengths_dp_unit #(
  parameter int MAX_TOTAL = 1023
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mptl_pkg::LEN_W-1:0] in_total_time,
  input  logic [mptl_pkg::LEN_W-1:0] in_length_a,
  input  logic [mptl_pkg::LEN_W-1:0] in_length_b,
  input  logic [mptl_pkg::LEN_W-1:0] in_length_c,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_status,
  output logic [mptl_pkg::LEN_W-1:0] out_used_time,
  output logic [mptl_pkg::LEN_W-1:0] out_leftover_time,
  output logic [mptl_pkg::LEN_W-1:0] out_task_count,
  output logic [mptl_pkg::LEN_W-1:0] out_uses_a,
  output logic [mptl_pkg::LEN_W-1:0] out_uses_b,
  output logic [mptl_pkg::LEN_W-1:0] out_uses_c
);

  localparam int TOTAL_CAP = (MAX_TOTAL < mptl_pkg::TIME_MAX) ? MAX_TOTAL
                                                              : mptl_pkg::TIME_MAX;
  localparam int DEPTH = TOTAL_CAP + 1;
  localparam int AW    = $clog2(DEPTH);

  logic                       busy;
  logic                       res_valid;
  logic                       res_take;
  mptl_pkg::mptl_result_t     res;
  mptl_pkg::mptl_result_t     res_r;
  logic                       out_valid_r, out_valid_nxt;

  logic                       cnt_we;
  logic [AW-1:0]              cnt_waddr;
  logic [mptl_pkg::CNT_W-1:0] cnt_wdata;
  logic [AW-1:0]              cnt_raddr0;
  logic [AW-1:0]              cnt_raddr1;
  logic [mptl_pkg::CNT_W-1:0] cnt_rdata0;
  logic [mptl_pkg::CNT_W-1:0] cnt_rdata1;
  logic                       pred_we;
  logic [AW-1:0]              pred_waddr;
  logic [AW-1:0]              pred_wdata;
  logic [AW-1:0]              pred_raddr;
  logic [AW-1:0]              pred_rdata;

  mptl_tables #(.DEPTH(DEPTH), .AW(AW)) u_tables (
    .clk        (clk),
    .cnt_we     (cnt_we),
    .cnt_waddr  (cnt_waddr),
    .cnt_wdata  (cnt_wdata),
    .cnt_raddr0 (cnt_raddr0),
    .cnt_raddr1 (cnt_raddr1),
    .cnt_rdata0 (cnt_rdata0),
    .cnt_rdata1 (cnt_rdata1),
    .pred_we    (pred_we),
    .pred_waddr (pred_waddr),
    .pred_wdata (pred_wdata),
    .pred_raddr (pred_raddr),
    .pred_rdata (pred_rdata)
  );

  mptl_seq #(.TOTAL_CAP(TOTAL_CAP), .AW(AW)) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_total_time (in_total_time),
    .in_length_a   (in_length_a),
    .in_length_b   (in_length_b),
    .in_length_c   (in_length_c),
    .busy          (busy),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res),
    .cnt_we        (cnt_we),
    .cnt_waddr     (cnt_waddr),
    .cnt_wdata     (cnt_wdata),
    .cnt_raddr0    (cnt_raddr0),
    .cnt_raddr1    (cnt_raddr1),
    .cnt_rdata0    (cnt_rdata0),
    .cnt_rdata1    (cnt_rdata1),
    .pred_we       (pred_we),
    .pred_waddr    (pred_waddr),
    .pred_wdata    (pred_wdata),
    .pred_raddr    (pred_raddr),
    .pred_rdata    (pred_rdata)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      res_r <= res;
    end
  end

  assign in_stall          = busy;
  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_used_time     = res_r.used_time;
  assign out_leftover_time = res_r.leftover_time;
  assign out_task_count    = res_r.task_count;
  assign out_uses_a        = res_r.uses_a;
  assign out_uses_b        = res_r.uses_b;
  assign out_uses_c        = res_r.uses_c;

endmodule

[tb/mptl_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the max-pieces three-lengths DP unit: predicts each result
// from the accepted requests and compares it with what the unit returns.
// Depends on mptl_pkg for widths, the result struct and the unreachable mark.
module mptl_result_checker #(
  parameter int MAX_TOTAL = 1023
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [mptl_pkg::LEN_W-1:0] in_total_time,
  input  logic [mptl_pkg::LEN_W-1:0] in_length_a,
  input  logic [mptl_pkg::LEN_W-1:0] in_length_b,
  input  logic [mptl_pkg::LEN_W-1:0] in_length_c,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_status,
  input  logic [mptl_pkg::LEN_W-1:0] out_used_time,
  input  logic [mptl_pkg::LEN_W-1:0] out_leftover_time,
  input  logic [mptl_pkg::LEN_W-1:0] out_task_count,
  input  logic [mptl_pkg::LEN_W-1:0] out_uses_a,
  input  logic [mptl_pkg::LEN_W-1:0] out_uses_b,
  input  logic [mptl_pkg::LEN_W-1:0] out_uses_c,
  output int                         fail_count,
  output int                         pending
);

  logic [mptl_pkg::CNT_W-1:0] best_count [0:MAX_TOTAL];
  logic [mptl_pkg::LEN_W-1:0] prev_time  [0:MAX_TOTAL];
  mptl_pkg::mptl_result_t     expected_results[$];
  int                         errors = 0;

  function automatic logic [mptl_pkg::CNT_W-1:0] count_without(int t, int len);
    if (len == 0 || len > t) begin
      return mptl_pkg::UNREACH;
    end
    return best_count[t - len];
  endfunction

  function automatic bit no_worse(logic [mptl_pkg::CNT_W-1:0] x,
                                  logic [mptl_pkg::CNT_W-1:0] y);
    if (x == mptl_pkg::UNREACH) begin
      return y == mptl_pkg::UNREACH;
    end
    if (y == mptl_pkg::UNREACH) begin
      return 1'b1;
    end
    return x >= y;
  endfunction

  function automatic mptl_pkg::mptl_result_t fill_max_pieces(int total, int la, int lb,
                                                             int lc);
    mptl_pkg::mptl_result_t     res;
    logic [mptl_pkg::CNT_W-1:0] ca, cb, cc, best;
    int                         len, used, t, back, step, ua, ub, uc;
    res = '0;
    ua = 0;
    ub = 0;
    uc = 0;
    if (total > MAX_TOTAL) begin
      total = MAX_TOTAL;
    end
    best_count[0] = '0;
    prev_time[0]  = '0;
    for (t = 1; t <= total; t++) begin
      ca = count_without(t, la);
      cb = count_without(t, lb);
      cc = count_without(t, lc);
      if (no_worse(ca, cb) && no_worse(ca, cc)) begin
        best = ca;
        len  = la;
      end else if (no_worse(cb, ca) && no_worse(cb, cc)) begin
        best = cb;
        len  = lb;
      end else begin
        best = cc;
        len  = lc;
      end
      if (best == mptl_pkg::UNREACH) begin
        best_count[t] = mptl_pkg::UNREACH;
      end else begin
        best_count[t] = best + 1'b1;
        prev_time[t]  = mptl_pkg::LEN_W'(t - len);
      end
    end
    used = total;
    while (used > 0 && best_count[used] == mptl_pkg::UNREACH) begin
      used--;
    end
    if (used == 0 && total != 0) begin
      res.status        = 1'b1;
      res.leftover_time = mptl_pkg::LEN_W'(total);
      return res;
    end
    t = used;
    while (t > 0) begin
      back = prev_time[t];
      if (back >= t) begin
        break;
      end
      step = t - back;
      if (step == la) ua++;
      if (step == lb) ub++;
      if (step == lc) uc++;
      t = back;
    end
    res.used_time     = mptl_pkg::LEN_W'(used);
    res.leftover_time = mptl_pkg::LEN_W'(total - used);
    res.task_count    = best_count[used][mptl_pkg::LEN_W-1:0];
    res.uses_a        = mptl_pkg::LEN_W'(ua);
    res.uses_b        = mptl_pkg::LEN_W'(ub);
    res.uses_c        = mptl_pkg::LEN_W'(uc);
    return res;
  endfunction

  always @(posedge clk) begin
    mptl_pkg::mptl_result_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_used_time, out_leftover_time, out_task_count,
                out_uses_a, out_uses_b, out_uses_c};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: status=%0d used=%0d left=%0d cnt=%0d a=%0d b=%0d c=%0d",
                     got.status, got.used_time, got.leftover_time, got.task_count,
                     got.uses_a, got.uses_b, got.uses_c);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.used_time !== want.used_time ||
              got.leftover_time !== want.leftover_time ||
              got.task_count !== want.task_count || got.uses_a !== want.uses_a ||
              got.uses_b !== want.uses_b || got.uses_c !== want.uses_c) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp status=%0d used=%0d left=%0d cnt=%0d a=%0d b=%0d c=%0d",
                       want.status, want.used_time, want.leftover_time, want.task_count,
                       want.uses_a, want.uses_b, want.uses_c);
              $display("          got status=%0d used=%0d left=%0d cnt=%0d a=%0d b=%0d c=%0d",
                       got.status, got.used_time, got.leftover_time, got.task_count,
                       got.uses_a, got.uses_b, got.uses_c);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(fill_max_pieces(in_total_time, in_length_a,
                                                   in_length_b, in_length_c));
      end
    end
    pending    <= expected_results.size();
    fail_count <= errors;
  end

endmodule

[tb/tb_max_pieces_three_lengths_dp_unit.sv]
`timescale 1ns / 1ps
// Top of the max-pieces three-lengths DP unit testbench: clock, reset, request
// stimulus, result-side stalls, watchdog and verdict.
// Depends on mptl_pkg, max_pieces_three_lengths_dp_unit and mptl_result_checker.
module tb_max_pieces_three_lengths_dp_unit;

  localparam int MAX_TOTAL  = 1023;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 400;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [mptl_pkg::LEN_W-1:0] in_total_time = '0;
  logic [mptl_pkg::LEN_W-1:0] in_length_a = '0;
  logic [mptl_pkg::LEN_W-1:0] in_length_b = '0;
  logic [mptl_pkg::LEN_W-1:0] in_length_c = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_status;
  logic [mptl_pkg::LEN_W-1:0] out_used_time;
  logic [mptl_pkg::LEN_W-1:0] out_leftover_time;
  logic [mptl_pkg::LEN_W-1:0] out_task_count;
  logic [mptl_pkg::LEN_W-1:0] out_uses_a;
  logic [mptl_pkg::LEN_W-1:0] out_uses_b;
  logic [mptl_pkg::LEN_W-1:0] out_uses_c;
  int                         fail_count;
  int                         pending;
  int                         burst_left = 0;
  int                         idle_cycles = 0;
  int                         results_seen = 0;
  int                         stall_mode = 0;
  int                         mode_left = 0;
  int                         hold_left = 0;
  bit                         hold_done = 1'b0;

  max_pieces_three_lengths_dp_unit #(
    .MAX_TOTAL(MAX_TOTAL)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_total_time    (in_total_time),
    .in_length_a      (in_length_a),
    .in_length_b      (in_length_b),
    .in_length_c      (in_length_c),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_used_time    (out_used_time),
    .out_leftover_time(out_leftover_time),
    .out_task_count   (out_task_count),
    .out_uses_a       (out_uses_a),
    .out_uses_b       (out_uses_b),
    .out_uses_c       (out_uses_c)
  );

  mptl_result_checker #(
    .MAX_TOTAL(MAX_TOTAL)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_total_time    (in_total_time),
    .in_length_a      (in_length_a),
    .in_length_b      (in_length_b),
    .in_length_c      (in_length_c),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_used_time    (out_used_time),
    .out_leftover_time(out_leftover_time),
    .out_task_count   (out_task_count),
    .out_uses_a       (out_uses_a),
    .out_uses_b       (out_uses_b),
    .out_uses_c       (out_uses_c),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one request: optional gap between bursts, then hold until accepted
  task automatic offer_request(int total, int la, int lb, int lc);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    in_valid      <= 1'b1;
    in_total_time <= mptl_pkg::LEN_W'(total);
    in_length_a   <= mptl_pkg::LEN_W'(la);
    in_length_b   <= mptl_pkg::LEN_W'(lb);
    in_length_c   <= mptl_pkg::LEN_W'(lc);
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic int pick_length();
    if ($urandom_range(0, 5) == 0) begin
      return $urandom_range(1, 1023);
    end
    return $urandom_range(1, 24);
  endfunction

  initial begin
    int total, la, lb, lc, size_sel;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_request(0, 1, 2, 3);
    offer_request(0, 1023, 1023, 1023);
    offer_request(1023, 1, 1, 1);
    offer_request(1023, 1023, 1023, 1023);
    offer_request(5, 7, 8, 9);
    offer_request(1, 2, 4, 6);
    offer_request(17, 5, 3, 2);
    offer_request(10, 3, 3, 5);
    offer_request(12, 4, 6, 4);
    offer_request(11, 2, 5, 5);
    offer_request(7, 0, 3, 2);
    offer_request(9, 0, 0, 4);
    offer_request(6, 0, 0, 0);
    offer_request(1023, 512, 511, 1);
    offer_request(682, 341, 682, 1);
    offer_request(341, 682, 1, 3);
    offer_request(100, 7, 11, 13);
    offer_request(999, 1000, 998, 997);
    wait_drained();

    for (int n = 0; n < 172; n++) begin
      size_sel = $urandom_range(0, 15);
      if (size_sel == 0) begin
        total = $urandom_range(0, 1023);
      end else if (size_sel < 4) begin
        total = $urandom_range(0, 255);
      end else begin
        total = $urandom_range(0, 48);
      end
      la = pick_length();
      lb = pick_length();
      lc = pick_length();
      if ($urandom_range(0, 7) == 0) lb = la;
      if ($urandom_range(0, 7) == 0) lc = lb;
      offer_request(total, la, lb, lc);
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result-side stalls: random modes, plus one long hold once results flow
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      results_seen++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
